// ===== rtl/next_fit_heap_allocator_unit_assert.svh =====
// assertion macros for the next-fit heap allocator
// used by the top level; expects clk and rst_n in scope
`ifndef NEXT_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define NFHA_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define NFHA_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define NFHA_ASSERT_IMP(lbl, pre, post, msg)
`define NFHA_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/nfha_pkg.sv =====
// shared types and constants of the next-fit heap allocator
// no dependencies
`timescale 1ns / 1ps
package nfha_pkg;

    localparam int HEAP_WORDS_DEF = 4096;
    localparam int NEED_W = 13;
    localparam int REQ_W = 14;
    localparam int ADDR_W = 32;
    localparam int GB_W = 15;
    localparam int ST_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [ST_W-1:0] ST_OK = 3'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 3'd1;
    localparam logic [ST_W-1:0] ST_CORRUPT = 3'd2;
    localparam logic [ST_W-1:0] ST_INVALID = 3'd3;
    localparam logic [ST_W-1:0] ST_DOUBLE = 3'd4;
    localparam logic [ST_W-1:0] ST_DISABLED = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_READY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'd1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLR,
        OP_START,
        OP_WRAP,
        OP_RD_IDX,
        OP_ADV,
        OP_TAKE,
        OP_SPLIT,
        OP_RD_W,
        OP_OWN,
        OP_RD_NXT,
        OP_MERGE_N,
        OP_WR_W,
        OP_WALK,
        OP_MERGE_P,
        OP_CLR_W,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [ST_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic heap_ready;
        logic is_free;
        logic free_ok;
        logic idx_ok;
        logic pass2;
        logic hdr_valid;
        logic hdr_used;
        logic hdr_zero;
        logic hdr_small;
        logic nxt_ok;
        logic w_zero;
        logic walk_ok;
        logic prev_used;
    } stat_t;

endpackage

// ===== rtl/nfha_if.sv =====
// request and response channels of the heap allocator
// depends on nfha_pkg for field widths
`timescale 1ns / 1ps
interface nfha_req_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [nfha_pkg::REQ_W-1:0]  req_bytes;
    logic [nfha_pkg::ADDR_W-1:0] free_addr;
    modport source (output valid, mode, req_bytes, free_addr, input ready);
    modport sink (input valid, mode, req_bytes, free_addr, output ready);
endinterface

interface nfha_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [nfha_pkg::ST_W-1:0]   status;
    logic [nfha_pkg::ADDR_W-1:0] addr;
    logic [nfha_pkg::GB_W-1:0]   granted_bytes;
    modport source (output valid, status, addr, granted_bytes, input ready);
    modport sink (input valid, status, addr, granted_bytes, output ready);
endinterface

// ===== rtl/nfha_datapath.sv =====
// datapath: header store, rover, walk registers and result register
// depends on nfha_pkg; driven by nfha_controller commands
`timescale 1ns / 1ps
module nfha_datapath #(
    parameter int HEAP_WORDS = nfha_pkg::HEAP_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nfha_pkg::cmd_t                 cmd,
    output nfha_pkg::stat_t                stat,
    input  logic                           cfg_we,
    input  logic [nfha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           mode,
    input  logic [nfha_pkg::REQ_W-1:0]     req_bytes,
    input  logic [nfha_pkg::ADDR_W-1:0]    free_addr,
    output logic [nfha_pkg::ST_W-1:0]      status,
    output logic [nfha_pkg::ADDR_W-1:0]    addr,
    output logic [nfha_pkg::GB_W-1:0]      granted_bytes
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int RW = $clog2(HEAP_WORDS + 1);
    localparam int SW = RW;
    localparam int IW = RW + 1;
    localparam int HDR_W = SW + 2;
    localparam logic [31:0] HW32 = 32'(HEAP_WORDS);
    localparam int NW = nfha_pkg::NEED_W;

    // header layout: valid, used, size in words
    logic [HDR_W-1:0] mem [HEAP_WORDS];
    logic [HDR_W-1:0] rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [AW-1:0]    mem_ra;
    logic [HDR_W-1:0] mem_wd;

    logic        ready_reg;
    logic [31:0] base_reg;

    logic [RW-1:0] rover_reg, rover_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          mode_reg, mode_next;
    logic [NW-1:0] need_reg, need_next;
    logic [34:0]   off_reg, off_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          pass_reg, pass_next;
    logic [AW-1:0] where_reg, where_next;
    logic [SW-1:0] rest_reg, rest_next;
    logic [SW-1:0] own_reg, own_next;
    logic [SW-1:0] bsz_reg, bsz_next;
    logic [IW-1:0] nxt_reg, nxt_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic [SW-1:0] psz_reg, psz_next;
    logic          pused_reg, pused_next;
    logic [nfha_pkg::ST_W-1:0]   res_st_reg, res_st_next;
    logic [nfha_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [nfha_pkg::GB_W-1:0]   res_gb_reg, res_gb_next;

    logic          h_valid, h_used;
    logic [SW-1:0] h_size;
    logic [AW-1:0] w_idx;
    logic [14:0]   round;
    logic [31:0]   where1;
    logic [31:0]   own32;

    assign h_valid = rdata_reg[SW+1];
    assign h_used  = rdata_reg[SW];
    assign h_size  = rdata_reg[SW-1:0];
    assign w_idx   = off_reg[AW+1:2];
    assign round   = {1'b0, req_bytes} + 15'd3;
    assign where1  = 32'(where_reg) + 32'd1;
    assign own32   = 32'(own_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    always_comb
    begin
        mem_we        = 1'b0;
        mem_wa        = idx_reg[AW-1:0];
        mem_ra        = idx_reg[AW-1:0];
        mem_wd        = '0;
        rover_next    = rover_reg;
        clr_next      = clr_reg;
        mode_next     = mode_reg;
        need_next     = need_reg;
        off_next      = off_reg;
        idx_next      = idx_reg;
        pass_next     = pass_reg;
        where_next    = where_reg;
        rest_next     = rest_reg;
        own_next      = own_reg;
        bsz_next      = bsz_reg;
        nxt_next      = nxt_reg;
        prev_next     = prev_reg;
        psz_next      = psz_reg;
        pused_next    = pused_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        res_gb_next   = res_gb_reg;
        case (cmd.op)
            nfha_pkg::OP_CLR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = (clr_reg == '0) ? {2'b10, SW'(HEAP_WORDS)} : '0;
                clr_next = clr_reg + AW'(1);
            end
            nfha_pkg::OP_START:
            begin
                mode_next = mode;
                need_next = NW'(round[14:2]) + NW'(1);
                off_next  = {3'b000, free_addr} - 35'd4 - {3'b000, base_reg};
                idx_next  = IW'(rover_reg);
                pass_next = 1'b0;
            end
            nfha_pkg::OP_WRAP:
            begin
                idx_next  = '0;
                pass_next = 1'b1;
            end
            nfha_pkg::OP_RD_IDX:
            begin
                mem_ra = idx_reg[AW-1:0];
            end
            nfha_pkg::OP_ADV:
            begin
                idx_next = idx_reg + IW'(h_size);
            end
            nfha_pkg::OP_TAKE:
            begin
                mem_we     = 1'b1;
                mem_wa     = idx_reg[AW-1:0];
                mem_wd     = {2'b11, SW'(need_reg)};
                rover_next = RW'(32'(idx_reg) + 32'(need_reg));
                where_next = idx_reg[AW-1:0];
                rest_next  = h_size - SW'(need_reg);
                nxt_next   = IW'(32'(idx_reg) + 32'(need_reg));
            end
            nfha_pkg::OP_SPLIT:
            begin
                // remainder header only when it is nonzero and lands inside the heap
                if (rest_reg != '0 && 32'(nxt_reg) < HW32)
                begin
                    mem_we = 1'b1;
                    mem_wa = nxt_reg[AW-1:0];
                    mem_wd = {2'b10, rest_reg};
                end
            end
            nfha_pkg::OP_RD_W:
            begin
                mem_ra = w_idx;
            end
            nfha_pkg::OP_OWN:
            begin
                own_next = h_size;
                bsz_next = h_size;
                nxt_next = IW'(w_idx) + IW'(h_size);
            end
            nfha_pkg::OP_RD_NXT:
            begin
                mem_ra = nxt_reg[AW-1:0];
            end
            nfha_pkg::OP_MERGE_N:
            begin
                bsz_next = bsz_reg + h_size;
                mem_we   = 1'b1;
                mem_wa   = nxt_reg[AW-1:0];
                mem_wd   = '0;
            end
            nfha_pkg::OP_WR_W:
            begin
                mem_we     = 1'b1;
                mem_wa     = w_idx;
                mem_wd     = {2'b10, bsz_reg};
                rover_next = RW'(w_idx);
                idx_next   = '0;
            end
            nfha_pkg::OP_WALK:
            begin
                prev_next  = idx_reg[AW-1:0];
                psz_next   = h_size;
                pused_next = h_used;
                idx_next   = idx_reg + IW'(h_size);
            end
            nfha_pkg::OP_MERGE_P:
            begin
                mem_we     = 1'b1;
                mem_wa     = prev_reg;
                mem_wd     = {2'b10, bsz_reg + psz_reg};
                rover_next = RW'(prev_reg);
            end
            nfha_pkg::OP_CLR_W:
            begin
                mem_we = 1'b1;
                mem_wa = w_idx;
                mem_wd = '0;
            end
            nfha_pkg::OP_FINISH:
            begin
                res_st_next   = cmd.code;
                res_addr_next = '0;
                res_gb_next   = '0;
                if (cmd.code == nfha_pkg::ST_OK)
                begin
                    if (mode_reg)
                    begin
                        res_gb_next = {own32[12:0], 2'b00};
                    end
                    else
                    begin
                        res_addr_next = base_reg + {where1[29:0], 2'b00};
                        res_gb_next   = {need_reg, 2'b00};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            base_reg  <= '0;
            rover_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            rover_reg <= rover_next;
            clr_reg   <= clr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    nfha_pkg::CFG_HEAP_READY: ready_reg <= cfg_wdata[0];
                    nfha_pkg::CFG_HEAP_BASE:  base_reg <= {cfg_wdata[31:2], 2'b00};
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        need_reg     <= need_next;
        off_reg      <= off_next;
        idx_reg      <= idx_next;
        pass_reg     <= pass_next;
        where_reg    <= where_next;
        rest_reg     <= rest_next;
        own_reg      <= own_next;
        bsz_reg      <= bsz_next;
        nxt_reg      <= nxt_next;
        prev_reg     <= prev_next;
        psz_reg      <= psz_next;
        pused_reg    <= pused_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        res_gb_reg   <= res_gb_next;
    end

    assign stat.clr_done   = (clr_reg == AW'(HEAP_WORDS - 1));
    assign stat.heap_ready = ready_reg;
    assign stat.is_free    = mode_reg;
    assign stat.free_ok    = !off_reg[34] && (off_reg[1:0] == 2'b00) && (off_reg[33:2] < HW32);
    assign stat.idx_ok     = 32'(idx_reg) < (pass_reg ? 32'(rover_reg) : HW32);
    assign stat.pass2      = pass_reg;
    assign stat.hdr_valid  = h_valid;
    assign stat.hdr_used   = h_used;
    assign stat.hdr_zero   = (h_size == '0);
    assign stat.hdr_small  = 32'(h_size) < 32'(need_reg);
    assign stat.nxt_ok     = 32'(nxt_reg) < HW32;
    assign stat.w_zero     = (w_idx == '0);
    assign stat.walk_ok    = 32'(idx_reg) < 32'(w_idx);
    assign stat.prev_used  = pused_reg;

    assign status        = res_st_reg;
    assign addr          = res_addr_reg;
    assign granted_bytes = res_gb_reg;

endmodule

// ===== rtl/nfha_controller.sv =====
// controller: sequences clearing, allocation search and free merging
// depends on nfha_pkg; commands nfha_datapath
`timescale 1ns / 1ps
module nfha_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nfha_pkg::stat_t       stat,
    output nfha_pkg::cmd_t        cmd,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready
);

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_DISPATCH = 15'b000000000000100,
        S_A_RD     = 15'b000000000001000,
        S_A_CHK    = 15'b000000000010000,
        S_A_SPLIT  = 15'b000000000100000,
        S_F_HW     = 15'b000000001000000,
        S_F_NXT    = 15'b000000010000000,
        S_F_NCHK   = 15'b000000100000000,
        S_F_WRW    = 15'b000001000000000,
        S_F_WRD    = 15'b000010000000000,
        S_F_WCHK   = 15'b000100000000000,
        S_F_PREV   = 15'b001000000000000,
        S_F_CLRW   = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [nfha_pkg::ST_W-1:0] code_reg, code_next;
    logic                      rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        cmd.op         = nfha_pkg::OP_NOP;
        cmd.code       = code_reg;
        req_ready      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = nfha_pkg::OP_CLR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = nfha_pkg::OP_START;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!stat.heap_ready)
                begin
                    code_next  = nfha_pkg::ST_DISABLED;
                    state_next = S_DONE;
                end
                else if (!stat.is_free)
                begin
                    state_next = S_A_RD;
                end
                else if (!stat.free_ok)
                begin
                    code_next  = nfha_pkg::ST_INVALID;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = nfha_pkg::OP_RD_W;
                    state_next = S_F_HW;
                end
            end
            S_A_RD:
            begin
                if (stat.idx_ok)
                begin
                    cmd.op     = nfha_pkg::OP_RD_IDX;
                    state_next = S_A_CHK;
                end
                else if (!stat.pass2)
                begin
                    // second pass from word zero up to the rover
                    cmd.op = nfha_pkg::OP_WRAP;
                end
                else
                begin
                    code_next  = nfha_pkg::ST_NOSPACE;
                    state_next = S_DONE;
                end
            end
            S_A_CHK:
            begin
                if (stat.hdr_zero)
                begin
                    code_next  = nfha_pkg::ST_CORRUPT;
                    state_next = S_DONE;
                end
                else if (stat.hdr_used || stat.hdr_small)
                begin
                    cmd.op     = nfha_pkg::OP_ADV;
                    state_next = S_A_RD;
                end
                else
                begin
                    cmd.op     = nfha_pkg::OP_TAKE;
                    state_next = S_A_SPLIT;
                end
            end
            S_A_SPLIT:
            begin
                cmd.op     = nfha_pkg::OP_SPLIT;
                code_next  = nfha_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_F_HW:
            begin
                if (!stat.hdr_valid)
                begin
                    code_next  = nfha_pkg::ST_INVALID;
                    state_next = S_DONE;
                end
                else if (!stat.hdr_used)
                begin
                    code_next  = nfha_pkg::ST_DOUBLE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = nfha_pkg::OP_OWN;
                    state_next = S_F_NXT;
                end
            end
            S_F_NXT:
            begin
                if (stat.nxt_ok)
                begin
                    cmd.op     = nfha_pkg::OP_RD_NXT;
                    state_next = S_F_NCHK;
                end
                else
                begin
                    state_next = S_F_WRW;
                end
            end
            S_F_NCHK:
            begin
                if (stat.hdr_used)
                begin
                    state_next = S_F_WRW;
                end
                else if (stat.hdr_zero)
                begin
                    code_next  = nfha_pkg::ST_CORRUPT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = nfha_pkg::OP_MERGE_N;
                    state_next = S_F_WRW;
                end
            end
            S_F_WRW:
            begin
                cmd.op    = nfha_pkg::OP_WR_W;
                code_next = nfha_pkg::ST_OK;
                state_next = stat.w_zero ? S_DONE : S_F_WRD;
            end
            S_F_WRD:
            begin
                if (stat.walk_ok)
                begin
                    cmd.op     = nfha_pkg::OP_RD_IDX;
                    state_next = S_F_WCHK;
                end
                else
                begin
                    state_next = S_F_PREV;
                end
            end
            S_F_WCHK:
            begin
                if (stat.hdr_zero)
                begin
                    code_next  = nfha_pkg::ST_CORRUPT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = nfha_pkg::OP_WALK;
                    state_next = S_F_WRD;
                end
            end
            S_F_PREV:
            begin
                if (!stat.prev_used)
                begin
                    cmd.op     = nfha_pkg::OP_MERGE_P;
                    state_next = S_F_CLRW;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F_CLRW:
            begin
                cmd.op     = nfha_pkg::OP_CLR_W;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait until the previous result has been taken
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.op         = nfha_pkg::OP_FINISH;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            code_reg      <= nfha_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/next_fit_heap_allocator_unit.sv =====
// Next-fit heap allocator. After reset a clearing pass writes every header word before the first
// item is taken; configuration writes are taken throughout. One item is worked at a time through
// a header store with one write port, one read port and a registered read, so each header visited
// is read in one state and checked in the next: an allocation walks the headers from the rover on,
// a free walks the headers from word zero up to the freed block. A new item is taken while the
// previous result still waits on the response channel.
`timescale 1ns / 1ps
`include "next_fit_heap_allocator_unit_assert.svh"
module next_fit_heap_allocator_unit #(
    parameter int HEAP_WORDS = nfha_pkg::HEAP_WORDS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    nfha_req_if.sink                      req,
    nfha_rsp_if.source                    rsp,
    input logic                           cfg_we,
    input logic [nfha_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [31:0]                    cfg_wdata
);

    nfha_pkg::cmd_t  cmd;
    nfha_pkg::stat_t stat;
    logic            req_take;
    logic            fin_now;
    logic            rsp_err;
    logic            rsp_clear;

    nfha_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .cmd       (cmd),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready)
    );

    nfha_datapath #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mode          (req.mode),
        .req_bytes     (req.req_bytes),
        .free_addr     (req.free_addr),
        .status        (rsp.status),
        .addr          (rsp.addr),
        .granted_bytes (rsp.granted_bytes)
    );

    assign req_take  = req.valid && req.ready;
    assign fin_now   = (cmd.op == nfha_pkg::OP_FINISH);
    assign rsp_err   = rsp.valid && (rsp.status != nfha_pkg::ST_OK);
    assign rsp_clear = (rsp.addr == '0) && (rsp.granted_bytes == '0);

    `NFHA_ASSERT_NXT(a_busy_after_accept, req_take, !req.ready, "item taken while busy")
    `NFHA_ASSERT_IMP(a_no_overwrite, fin_now, !rsp.valid || rsp.ready, "result overwritten")
    `NFHA_ASSERT_IMP(a_error_zero, rsp_err, rsp_clear, "error result not cleared")

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the next-fit heap allocator
// depends on nfha_pkg, nfha_if and next_fit_heap_allocator_unit
`timescale 1ns / 1ps
module tb;

    localparam int WORDS = nfha_pkg::HEAP_WORDS_DEF;
    localparam longint CYCLE_LIMIT = 50000000;

    typedef struct packed {
        logic        valid;
        logic        used;
        logic [22:0] size;
    } hdr_t;

    typedef struct packed {
        logic [nfha_pkg::ST_W-1:0]   status;
        logic [nfha_pkg::ADDR_W-1:0] addr;
        logic [nfha_pkg::GB_W-1:0]   gbytes;
    } rsp_t;

    typedef struct {
        logic                        mode;
        logic [nfha_pkg::REQ_W-1:0]  req_bytes;
        logic [nfha_pkg::ADDR_W-1:0] free_addr;
        bit                          typed;
        rsp_t                        want;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [nfha_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_wdata;

    nfha_req_if req_ch();
    nfha_rsp_if rsp_ch();

    next_fit_heap_allocator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // allocator shadow state
    hdr_t   heap_hdr [WORDS];
    longint rover_w;
    logic   heap_on;
    logic [31:0] heap_base_q;
    int     live_words[$];

    rsp_t   pending_rsp[$];
    int     mismatches;
    int     items_sent;
    int     allocs_ok;
    int     frees_ok;
    int     errors_seen;
    int     idle_pct;
    int     stall_pct;
    int     hold_left;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic hdr_t mk_hdr(bit used, longint size);
        hdr_t h;
        h.valid = 1'b1;
        h.used  = used;
        h.size  = size[22:0];
        return h;
    endfunction

    // 0 nothing found, 1 taken, 2 zero-size header met
    function automatic int fit_walk(longint start, longint lim, longint need,
                                    output longint where);
        longint idx;
        longint sz;
        idx = start;
        where = 0;
        while (idx < lim && idx < WORDS)
        begin
            sz = heap_hdr[idx].size;
            if (sz == 0)
                return 2;
            if (heap_hdr[idx].used || sz < need)
                idx += sz;
            else
            begin
                heap_hdr[idx] = mk_hdr(1, need);
                if (sz > need && idx + need < WORDS)
                    heap_hdr[idx + need] = mk_hdr(0, sz - need);
                rover_w = idx + need;
                where = idx;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic rsp_t alloc_predict(logic [nfha_pkg::REQ_W-1:0] rb);
        rsp_t r;
        longint need;
        longint where;
        longint gb;
        int hit;
        r = '0;
        need = (longint'(rb) + 3) / 4 + 1;
        hit = fit_walk(rover_w, WORDS, need, where);
        if (hit == 0)
            hit = fit_walk(0, rover_w, need, where);
        if (hit == 2)
            r.status = nfha_pkg::ST_CORRUPT;
        else if (hit == 0)
            r.status = nfha_pkg::ST_NOSPACE;
        else
        begin
            gb = need * 4;
            r.status = nfha_pkg::ST_OK;
            r.addr = heap_base_q + 32'(4 * (where + 1));
            r.gbytes = gb[nfha_pkg::GB_W-1:0];
            live_words.push_back(int'(where));
        end
        return r;
    endfunction

    function automatic rsp_t free_predict(logic [nfha_pkg::ADDR_W-1:0] fa);
        rsp_t r;
        longint p, b, top, w, own, bsz, nxt, idx, prev, psz, gb;
        r = '0;
        p = longint'({32'b0, fa}) - 4;
        b = longint'({32'b0, heap_base_q});
        top = b + 4 * WORDS;
        if (p < b || p >= top || ((p - b) & 3) != 0)
        begin
            r.status = nfha_pkg::ST_INVALID;
            return r;
        end
        w = (p - b) >> 2;
        if (!heap_hdr[w].valid)
        begin
            r.status = nfha_pkg::ST_INVALID;
            return r;
        end
        if (!heap_hdr[w].used)
        begin
            r.status = nfha_pkg::ST_DOUBLE;
            return r;
        end
        own = heap_hdr[w].size;
        bsz = own;
        nxt = w + own;
        // forward merge stops at the heap top
        if (nxt < WORDS && !heap_hdr[nxt].used)
        begin
            if (heap_hdr[nxt].size == 0)
            begin
                r.status = nfha_pkg::ST_CORRUPT;
                return r;
            end
            bsz += heap_hdr[nxt].size;
            heap_hdr[nxt] = '0;
        end
        heap_hdr[w] = mk_hdr(0, bsz);
        rover_w = w;
        foreach (live_words[i])
            if (live_words[i] == w)
            begin
                live_words.delete(i);
                break;
            end
        gb = own * 4;
        r.status = nfha_pkg::ST_OK;
        r.gbytes = gb[nfha_pkg::GB_W-1:0];
        if (w == 0)
            return r;
        idx = 0;
        prev = 0;
        psz = 0;
        while (idx < w)
        begin
            psz = heap_hdr[idx].size;
            if (psz == 0)
            begin
                // earlier writes of this free stay in place
                r = '0;
                r.status = nfha_pkg::ST_CORRUPT;
                return r;
            end
            prev = idx;
            idx += psz;
        end
        if (!heap_hdr[prev].used)
        begin
            heap_hdr[w] = '0;
            heap_hdr[prev] = mk_hdr(0, bsz + psz);
            rover_w = prev;
        end
        return r;
    endfunction

    function automatic rsp_t heap_predict(logic mode, logic [nfha_pkg::REQ_W-1:0] rb,
                                          logic [nfha_pkg::ADDR_W-1:0] fa);
        rsp_t r;
        r = '0;
        if (!heap_on)
            r.status = nfha_pkg::ST_DISABLED;
        else if (!mode)
            r = alloc_predict(rb);
        else
            r = free_predict(fa);
        return r;
    endfunction

    task automatic write_reg(logic [nfha_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        if (idx == nfha_pkg::CFG_HEAP_READY)
            heap_on = val[0];
        else
            heap_base_q = {val[31:2], 2'b00};
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic mode, logic [nfha_pkg::REQ_W-1:0] rb,
                             logic [nfha_pkg::ADDR_W-1:0] fa, bit typed, rsp_t want);
        rsp_t got;
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.mode = mode;
        req_ch.req_bytes = rb;
        req_ch.free_addr = fa;
        do
            @(posedge clk);
        while (!req_ch.ready);
        got = heap_predict(mode, rb, fa);
        pending_rsp.push_back(typed ? want : got);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain(int pad);
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (pad) @(negedge clk);
    endtask

    task automatic send_random(int n);
        logic mode;
        logic [nfha_pkg::REQ_W-1:0] rb;
        logic [nfha_pkg::ADDR_W-1:0] fa;
        int pick;
        int w;
        for (int i = 0; i < n; i++)
        begin
            mode = ($urandom_range(99) < 52) ? 1'b0 : 1'b1;
            rb = '0;
            fa = '0;
            pick = $urandom_range(99);
            if (!mode)
            begin
                if (pick < 70)
                    rb = nfha_pkg::REQ_W'($urandom_range(256));
                else if (pick < 90)
                    rb = nfha_pkg::REQ_W'($urandom_range(2048));
                else
                    rb = nfha_pkg::REQ_W'($urandom);
                fa = $urandom;
            end
            else
            begin
                rb = nfha_pkg::REQ_W'($urandom);
                if (pick < 75 && live_words.size() != 0)
                begin
                    w = live_words[$urandom_range(live_words.size() - 1)];
                    fa = heap_base_q + 32'(4 * (w + 1));
                end
                else if (pick < 85)
                    fa = heap_base_q + 32'(4 * ($urandom_range(WORDS - 1) + 1));
                else if (pick < 91)
                    fa = heap_base_q + 32'(4 * $urandom_range(WORDS))
                         + 32'($urandom_range(1, 3));
                else
                    fa = $urandom;
            end
            send_item(mode, rb, fa, 0, '0);
        end
    endtask

    // result checking
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d addr %h bytes %0d",
                             rsp_ch.status, rsp_ch.addr, rsp_ch.granted_bytes);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (want.status != nfha_pkg::ST_OK && want.status != nfha_pkg::ST_DISABLED)
                    errors_seen++;
                if (rsp_ch.status !== want.status || rsp_ch.addr !== want.addr
                    || rsp_ch.granted_bytes !== want.gbytes)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: want %0d/%h/%0d got %0d/%h/%0d",
                                 want.status, want.addr, want.gbytes, rsp_ch.status,
                                 rsp_ch.addr, rsp_ch.granted_bytes);
                end
                else if (want.status == nfha_pkg::ST_OK && want.addr != 0)
                    allocs_ok++;
                else if (want.status == nfha_pkg::ST_OK)
                    frees_ok++;
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        row_t rows[$];
        rsp_t none;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = nfha_pkg::CFG_HEAP_READY;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = 1'b0;
        req_ch.req_bytes = '0;
        req_ch.free_addr = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        mismatches = 0;
        items_sent = 0;
        allocs_ok = 0;
        frees_ok = 0;
        errors_seen = 0;
        none = '0;
        foreach (heap_hdr[i])
            heap_hdr[i] = '0;
        heap_hdr[0] = mk_hdr(0, WORDS);
        rover_w = 0;
        heap_on = 1'b0;
        heap_base_q = '0;

        // heap at 0x1000: extremes, error codes and a few merges
        rows = '{
            '{0, 14'd0,     32'h0,        1, '{nfha_pkg::ST_OK, 32'h1004, 15'd4}},
            '{0, 14'd16380, 32'h0,        1, '{nfha_pkg::ST_NOSPACE, 32'h0, 15'd0}},
            '{1, 14'd0,     32'h0,        1, '{nfha_pkg::ST_INVALID, 32'h0, 15'd0}},
            '{1, 14'd0,     32'h1004,     1, '{nfha_pkg::ST_OK, 32'h0, 15'd4}},
            '{1, 14'd0,     32'h1004,     1, '{nfha_pkg::ST_DOUBLE, 32'h0, 15'd0}},
            '{0, 14'd16380, 32'h0,        1, '{nfha_pkg::ST_OK, 32'h1004, 15'd16384}},
            '{1, 14'd0,     32'h1006,     1, '{nfha_pkg::ST_INVALID, 32'h0, 15'd0}},
            '{1, 14'd0,     32'h5004,     1, '{nfha_pkg::ST_INVALID, 32'h0, 15'd0}},
            '{1, 14'd0,     32'h1004,     1, '{nfha_pkg::ST_OK, 32'h0, 15'd16384}},
            '{0, 14'd1,     32'h0,        0, none},
            '{0, 14'd4,     32'h0,        0, none},
            '{0, 14'd5,     32'h0,        0, none},
            '{0, 14'd100,   32'h0,        0, none},
            '{1, 14'd0,     32'h1008,     0, none},
            '{1, 14'd0,     32'h1004,     0, none},
            '{0, 14'd3,     32'h0,        0, none},
            '{1, 14'd0,     32'hffffffff, 1, '{nfha_pkg::ST_INVALID, 32'h0, 15'd0}},
            '{1, 14'd0,     32'h1000,     1, '{nfha_pkg::ST_INVALID, 32'h0, 15'd0}},
            '{1, 14'd0,     32'h1010,     0, none},
            '{0, 14'd8191,  32'h0,        0, none},
            '{0, 14'h3fff,  32'h0,        0, none}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // still disabled after reset
        send_item(0, 14'd8, 32'h0, 1, '{nfha_pkg::ST_DISABLED, 32'h0, 15'd0});
        drain(20);
        write_reg(nfha_pkg::CFG_HEAP_READY, 32'h1);
        write_reg(nfha_pkg::CFG_HEAP_BASE, 32'h1000);
        foreach (rows[i])
            send_item(rows[i].mode, rows[i].req_bytes, rows[i].free_addr,
                      rows[i].typed, rows[i].want);
        drain(20);

        write_reg(nfha_pkg::CFG_HEAP_READY, 32'h0);
        send_random(10);
        drain(20);

        write_reg(nfha_pkg::CFG_HEAP_READY, 32'hffffffff);
        write_reg(nfha_pkg::CFG_HEAP_BASE, 32'h0);
        send_random(100);
        // sender waits for every result before going on
        drain(0);
        send_random(100);
        drain(20);

        write_reg(nfha_pkg::CFG_HEAP_BASE, 32'hffffffff);
        idle_pct = 48;
        send_random(150);
        drain(20);

        write_reg(nfha_pkg::CFG_HEAP_BASE, $urandom);
        idle_pct = 0;
        stall_pct = 48;
        // long receiver hold-off while items keep coming
        hold_left = 400;
        send_random(200);
        drain(20);

        write_reg(nfha_pkg::CFG_HEAP_BASE, 32'h1000);
        idle_pct = 37;
        stall_pct = 37;
        send_random(220);
        drain(50);

        $display("%0d items sent: %0d allocations and %0d frees granted, %0d error results",
                 items_sent, allocs_ok, frees_ok, errors_seen);
        $display("heap bases 0, top of memory and random; %0d mismatches", mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
